// File: hdl/delayed_pose_camera_to_world_macros.svh
// Assertion macros shared by the delayed-pose rotation block.
`ifndef DELAYED_POSE_CAMERA_TO_WORLD_MACROS_SVH
`define DELAYED_POSE_CAMERA_TO_WORLD_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DPCW_ASSERT_NOW(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define DPCW_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/dpcw_pkg.sv
// Shared types, codes and constants of the delayed-pose rotation block.
package dpcw_pkg;

   localparam logic OP_POSE = 1'b0;
   localparam logic OP_MEAS = 1'b1;

   localparam int CORDIC_STEPS = 20;
   localparam int MAC_STEPS    = 14;
   localparam int SQRT_STEPS   = 32;

   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [34:0] HALF_PI_Q30     = 35'sd1686629713;
   localparam logic signed [34:0] PI_Q30          = 35'sd3373259426;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic signed [34:0] atan_q30(input logic [4:0] idx);
      logic signed [34:0] r;
      begin
         case (idx)
            5'd0:    r = 35'sd843314856;
            5'd1:    r = 35'sd497837829;
            5'd2:    r = 35'sd263043836;
            5'd3:    r = 35'sd133525158;
            5'd4:    r = 35'sd67021686;
            5'd5:    r = 35'sd33543515;
            5'd6:    r = 35'sd16775850;
            5'd7:    r = 35'sd8388437;
            5'd8:    r = 35'sd4194282;
            5'd9:    r = 35'sd2097149;
            5'd10:   r = 35'sd1048575;
            5'd11:   r = 35'sd524287;
            5'd12:   r = 35'sd262143;
            5'd13:   r = 35'sd131071;
            5'd14:   r = 35'sd65535;
            5'd15:   r = 35'sd32767;
            5'd16:   r = 35'sd16383;
            5'd17:   r = 35'sd8191;
            5'd18:   r = 35'sd4095;
            5'd19:   r = 35'sd2047;
            default: r = 35'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

// File: hdl/dpcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dpcw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/dpcw_queue.sv
// Two-entry queue between the front and back parts.
module dpcw_queue import dpcw_pkg::*; #(
   parameter int WIDTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output q_status_type     status
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   assign head_data    = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

// File: hdl/dpcw_front.sv
// Front part: accepts items, keeps the pose history, fetches the delayed pose.
`include "delayed_pose_camera_to_world_macros.svh"
module dpcw_front import dpcw_pkg::*; #(
   parameter int HISTORY_DEPTH = 256,
   parameter int ANGLE_BITS    = 16,
   localparam int KEEP    = (ANGLE_BITS < 16) ? ANGLE_BITS : 16,
   localparam int ENTRY_W = 2 * KEEP + 96
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [135:0]       req_tdata,
   input  logic [0:0]         req_tuser,
   output logic               q_push,
   output logic [ENTRY_W-1:0] q_data,
   input  q_status_type       q_status
);

   localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = AW + 9;
   localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
   localparam logic [CW-1:0] LAST_C    = CW'(HISTORY_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C   = CW'(HISTORY_DEPTH);
   localparam logic F_IDLE = 1'b0;
   localparam logic F_READ = 1'b1;

   logic            clear_ff, clear_in;
   logic [AW-1:0]   clear_addr_ff, clear_addr_in;
   logic [AW-1:0]   newest_ff, newest_in;
   logic            fstate_ff, fstate_in;
   logic [95:0]     cam_ff;

   logic            accept, is_meas;
   logic [AW-1:0]   newest_next;
   logic [CW-1:0]   delay_c, delay_sat, newest_c, slot_c;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [2*KEEP-1:0] wr_data, rd_data;

   assign req_tready = !clear_ff && (fstate_ff == F_IDLE) && !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign is_meas    = (req_tuser[0] == OP_MEAS);

   assign newest_next = (newest_ff == LAST_SLOT) ? '0 : newest_ff + AW'(1);

   // Saturate the delay, then step back around the ring.
   assign delay_c   = CW'(req_tdata[135:128]);
   assign delay_sat = (delay_c > LAST_C) ? LAST_C : delay_c;
   assign newest_c  = CW'(newest_ff);
   assign slot_c    = (newest_c >= delay_sat) ? newest_c - delay_sat
                                              : newest_c + DEPTH_C - delay_sat;

   always_comb begin
      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = accept && !is_meas;
         wr_addr = newest_next;
         wr_data = {req_tdata[31 -: KEEP], req_tdata[15 -: KEEP]};
      end
   end

   dpcw_ram #(
      .WIDTH (2 * KEEP),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept && is_meas),
      .rd_addr (slot_c[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      newest_in     = newest_ff;
      fstate_in     = F_IDLE;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == LAST_SLOT) clear_in = 1'b0;
      end
      if (accept && !is_meas) newest_in = newest_next;
      if (fstate_ff == F_IDLE && accept && is_meas) fstate_in = F_READ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         newest_ff     <= LAST_SLOT;
         fstate_ff     <= F_IDLE;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         newest_ff     <= newest_in;
         fstate_ff     <= fstate_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_meas) cam_ff <= req_tdata[127:32];
   end

   assign q_push = (fstate_ff == F_READ);
   assign q_data = {cam_ff, rd_data};

   `DPCW_ASSERT_NEXT(a_meas_pushes, accept && is_meas, q_push, "measurement not queued")
   `DPCW_ASSERT_NOW(a_push_room, q_push, !q_status.full, "push into full queue")
   `DPCW_ASSERT_NEXT(a_pose_advances, accept && !is_meas,
      newest_ff == (($past(newest_ff) == LAST_SLOT) ? '0 : $past(newest_ff) + AW'(1)),
      "newest slot did not advance")

endmodule

// File: hdl/dpcw_back.sv
// Back part: CORDIC sine/cosine, multiply-accumulate sequencer, square root.
`include "delayed_pose_camera_to_world_macros.svh"
module dpcw_back import dpcw_pkg::*; #(
   parameter int ANGLE_BITS = 16,
   localparam int KEEP    = (ANGLE_BITS < 16) ? ANGLE_BITS : 16,
   localparam int ENTRY_W = 2 * KEEP + 96
) (
   input  logic               clock,
   input  logic               reset,
   output logic               q_pop,
   input  logic [ENTRY_W-1:0] q_data,
   input  q_status_type       q_status,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [127:0]       rsp_tdata
);

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_COR  = 3'd1;
   localparam logic [2:0] B_MAC  = 3'd2;
   localparam logic [2:0] B_SQRT = 3'd3;
   localparam logic [2:0] B_OUT  = 3'd4;
   localparam logic signed [67:0] RND_HALF = 68'sd536870912;
   localparam logic signed [67:0] W_MAX    = 68'sd2147483647;
   localparam logic signed [67:0] W_MIN    = -68'sd2147483648;

   logic [2:0]  state_ff, state_in;

   logic [15:0] yaw_ff, pitch_ff;
   logic signed [31:0] x_ff, y_ff, z_ff;

   logic signed [33:0] cx_ff, cy_ff;
   logic signed [34:0] cz_ff;
   logic [4:0]  cstep_ff;
   logic        csel_ff, cflip_ff;
   logic signed [33:0] sin_p_ff, cos_p_ff, sin_y_ff, cos_y_ff;

   logic [3:0]  mstep_ff;
   logic        mphase_ff;
   logic signed [67:0] prod_ff, acc_ff;
   logic signed [33:0] m_ff [4];
   logic signed [31:0] w0_ff, w1_ff, w2_ff;

   logic [63:0] sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [4:0]  sq_cnt_ff;

   logic        rsp_valid_ff;
   logic [127:0] rsp_data_ff;
   logic        out_load;

   // Unpack the queue head.
   logic [15:0] q_yaw, q_pitch;
   logic [KEEP+15:0] q_yaw_ext, q_pitch_ext;
   assign q_yaw_ext   = {q_data[KEEP-1:0], 16'd0};
   assign q_pitch_ext = {q_data[2*KEEP-1:KEEP], 16'd0};
   assign q_yaw       = q_yaw_ext[KEEP+15 -: 16];
   assign q_pitch     = q_pitch_ext[KEEP+15 -: 16];

   assign q_pop = (state_ff == B_IDLE) && !q_status.empty;

   // CORDIC start: scale to Q30 and fold into [-pi/2, pi/2].
   logic signed [16:0] ang_start;
   logic signed [34:0] z_raw, z_start;
   logic        flip_start;
   assign ang_start = csel_ff ? -17'(signed'(yaw_ff)) : 17'(signed'(pitch_ff));
   assign z_raw     = 35'(ang_start) <<< 17;
   always_comb begin
      z_start    = z_raw;
      flip_start = 1'b0;
      if (z_raw > HALF_PI_Q30) begin
         z_start    = z_raw - PI_Q30;
         flip_start = 1'b1;
      end else if (z_raw < -HALF_PI_Q30) begin
         z_start    = z_raw + PI_Q30;
         flip_start = 1'b1;
      end
   end

   // One CORDIC rotation.
   logic signed [33:0] dx, dy, nx, ny, fx, fy;
   logic signed [34:0] nz;
   logic        c_first;
   assign c_first = (cstep_ff == 5'd0);
   always_comb begin
      logic signed [33:0] ux, uy;
      logic signed [34:0] uz;
      ux = c_first ? CORDIC_GAIN_Q30 : cx_ff;
      uy = c_first ? 34'sd0 : cy_ff;
      uz = c_first ? z_start : cz_ff;
      dx = uy >>> cstep_ff;
      dy = ux >>> cstep_ff;
      if (uz >= 35'sd0) begin
         nx = ux - dx;
         ny = uy + dy;
         nz = uz - atan_q30(cstep_ff);
      end else begin
         nx = ux + dx;
         ny = uy - dy;
         nz = uz + atan_q30(cstep_ff);
      end
   end
   logic        flip_now;
   assign flip_now = c_first ? flip_start : cflip_ff;
   assign fx = flip_now ? -nx : nx;
   assign fy = flip_now ? -ny : ny;

   // Multiply sequencer operand selection.
   logic signed [33:0] opa, opb;
   logic        neg, clr;
   always_comb begin
      opa = '0;
      opb = '0;
      neg = 1'b0;
      clr = 1'b0;
      case (mstep_ff)
         4'd0:  begin opa = sin_p_ff; opb = sin_y_ff; end
         4'd1:  begin opa = cos_p_ff; opb = sin_y_ff; end
         4'd2:  begin opa = sin_p_ff; opb = cos_y_ff; end
         4'd3:  begin opa = cos_p_ff; opb = cos_y_ff; end
         4'd4:  begin opa = cos_y_ff; opb = 34'(x_ff); clr = 1'b1; end
         4'd5:  begin opa = m_ff[0];  opb = 34'(y_ff); end
         4'd6:  begin opa = m_ff[1];  opb = 34'(z_ff); end
         4'd7:  begin opa = cos_p_ff; opb = 34'(y_ff); clr = 1'b1; neg = 1'b1; end
         4'd8:  begin opa = sin_p_ff; opb = 34'(z_ff); end
         4'd9:  begin opa = sin_y_ff; opb = 34'(x_ff); clr = 1'b1; neg = 1'b1; end
         4'd10: begin opa = m_ff[2];  opb = 34'(y_ff); end
         4'd11: begin opa = m_ff[3];  opb = 34'(z_ff); end
         4'd12: begin opa = 34'(w2_ff); opb = 34'(w2_ff); clr = 1'b1; end
         4'd13: begin opa = 34'(w0_ff); opb = 34'(w0_ff); end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   logic signed [67:0] prod_in, sum, m_round, w_round;
   logic signed [31:0] w_sat;
   assign prod_in = opa * opb;
   assign sum     = (clr ? 68'sd0 : acc_ff) + (neg ? -prod_ff : prod_ff);
   assign m_round = (prod_ff + RND_HALF) >>> 30;
   assign w_round = (sum + RND_HALF) >>> 30;
   assign w_sat   = (w_round > W_MAX) ? 32'sh7FFFFFFF :
                    (w_round < W_MIN) ? 32'sh80000000 : w_round[31:0];

   // Square root step.
   logic [63:0] sq_trial;
   assign sq_trial = sq_res_ff + sq_bit_ff;

   assign out_load = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (q_pop) state_in = B_COR;
         B_COR:   if (cstep_ff == 5'(CORDIC_STEPS - 1) && csel_ff) state_in = B_MAC;
         B_MAC:   if (mphase_ff && mstep_ff == 4'(MAC_STEPS - 1)) state_in = B_SQRT;
         B_SQRT:  if (sq_cnt_ff == 5'(SQRT_STEPS - 1)) state_in = B_OUT;
         B_OUT:   if (out_load) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            yaw_ff    <= q_yaw;
            pitch_ff  <= q_pitch;
            x_ff      <= q_data[2*KEEP +: 32];
            y_ff      <= q_data[2*KEEP+32 +: 32];
            z_ff      <= q_data[2*KEEP+64 +: 32];
            cstep_ff  <= '0;
            csel_ff   <= 1'b0;
         end
         B_COR: begin
            cx_ff <= nx;
            cy_ff <= ny;
            cz_ff <= nz;
            if (c_first) cflip_ff <= flip_start;
            if (cstep_ff == 5'(CORDIC_STEPS - 1)) begin
               cstep_ff <= '0;
               csel_ff  <= 1'b1;
               if (csel_ff) begin
                  sin_y_ff <= fy;
                  cos_y_ff <= fx;
               end else begin
                  sin_p_ff <= fy;
                  cos_p_ff <= fx;
               end
            end else begin
               cstep_ff <= cstep_ff + 5'd1;
            end
            mstep_ff  <= '0;
            mphase_ff <= 1'b0;
         end
         B_MAC: begin
            mphase_ff <= ~mphase_ff;
            if (!mphase_ff) begin
               prod_ff <= prod_in;
            end else begin
               mstep_ff <= mstep_ff + 4'd1;
               if (mstep_ff < 4'd4) m_ff[mstep_ff[1:0]] <= m_round[33:0];
               else acc_ff <= sum;
               if (mstep_ff == 4'd6)  w0_ff <= w_sat;
               if (mstep_ff == 4'd8)  w1_ff <= w_sat;
               if (mstep_ff == 4'd11) w2_ff <= w_sat;
               if (mstep_ff == 4'd13) sq_v_ff <= sum[63:0];
            end
            sq_res_ff <= '0;
            sq_bit_ff <= 64'd1 << 62;
            sq_cnt_ff <= '0;
         end
         B_SQRT: begin
            if (sq_v_ff >= sq_trial) begin
               sq_v_ff   <= sq_v_ff - sq_trial;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
            sq_cnt_ff <= sq_cnt_ff + 5'd1;
         end
         B_OUT: begin
            if (out_load) begin
               rsp_data_ff <= {(|sq_res_ff[63:32]) ? 32'hFFFFFFFF : sq_res_ff[31:0],
                               w1_ff, w0_ff, w2_ff};
            end
         end
         default: begin
            cstep_ff <= '0;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `DPCW_ASSERT_NEXT(a_pop_starts, q_pop,
      state_ff == B_COR && cstep_ff == 5'd0 && !csel_ff, "pop did not start CORDIC")
   `DPCW_ASSERT_NEXT(a_sqrt_ends, state_ff == B_SQRT && sq_cnt_ff == 5'(SQRT_STEPS - 1),
      state_ff == B_OUT, "square root did not finish")
   `DPCW_ASSERT_NEXT(a_load_valid, out_load, rsp_valid_ff, "result load lost")

endmodule

// File: hdl/delayed_pose_camera_to_world.sv
// Top level of the delayed-pose camera-to-world rotation block.
// Path: history read, queue, two 20-step CORDIC passes, 14 multiply-accumulate steps
//   on one shared multiplier, square root, output register.
// Throughput: one pose tick per cycle while req_tready is high, which it is not
//   during the reset sweep, a history read or with the queue full; the back part
//   takes a new measurement only after finishing the last, and a two-entry queue
//   lets pose ticks keep flowing meanwhile.
// Reset: synchronous; after it the history is swept to zero, one slot per cycle over
//   all HISTORY_DEPTH slots, and no transaction is accepted until the sweep ends.
module delayed_pose_camera_to_world import dpcw_pkg::*; #(
   parameter int HISTORY_DEPTH = 256,
   parameter int ANGLE_BITS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // yaw_angle[15:0], pitch_angle[31:16], cam_x[63:32], cam_y[95:64],
   // cam_z[127:96], delay_ticks[135:128]
   input  logic [135:0] req_tdata,
   // operation[0]: pose tick or target measurement
   input  logic [0:0]   req_tuser,
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // world_forward[31:0], world_lateral[63:32], height_offset[95:64],
   // horizontal_distance[127:96]
   output logic [127:0] rsp_tdata
);

   // Each history slot holds the top bits of both angles.
   localparam int KEEP    = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
   localparam int ENTRY_W = 2 * KEEP + 96;

   logic               q_push, q_pop;
   logic [ENTRY_W-1:0] q_in_data, q_head;
   q_status_type       q_status;

   // Front: take transactions, write pose ticks, fetch the delayed pose.
   dpcw_front #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .ANGLE_BITS    (ANGLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_push     (q_push),
      .q_data     (q_in_data),
      .q_status   (q_status)
   );

   // Hold fetched measurements until the back part is free.
   dpcw_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head_data (q_head),
      .status    (q_status)
   );

   // Back: rotate the point and form the distance.
   dpcw_back #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_pop      (q_pop),
      .q_data     (q_head),
      .q_status   (q_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
